FILE: rtl/core/wcrbf_pkg.sv
// Package for the Wendland C2 RBF weight block.
// Holds the item payload structs and the register index codes.
// No dependencies.
package wcrbf_pkg;

   localparam int unsigned COORD_W  = 32;
   localparam int unsigned WEIGHT_W = 17;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 2'd3;

   localparam logic [COORD_W-1:0]  INV_RADIUS_RESET = 32'd65536;
   localparam logic [WEIGHT_W-1:0] ONE_Q16          = 17'd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                outside;
   } rsp_payload_type;

endpackage

FILE: rtl/core/wendland_c2_rbf_weight_top.sv
// Wendland C2 radial basis weight, top level: 40-stage pipeline.
// Depends on wcrbf_pkg.
//
// channel  | ports                              | direction
// req      | req_valid, req_stall, req_payload  | point in (x, y, z Q16.16)
// rsp      | rsp_valid, rsp_stall, rsp_payload  | weight Q1.16 and outside flag out
// csr      | csr_we, csr_index, csr_wdata       | register write in
//
// One item per cycle while the output is not stalled; the stages are the 32 one-bit square root
// stages plus abs diff, square, sum, scale, t/f and three polynomial multiply stages.
// Reset is synchronous and clears the valid bits and configuration registers to defaults.
// A stalled result freezes only the unbroken run of full stages behind it; bubbles
// collapse, so items keep entering while empty stages remain.
module wendland_c2_rbf_weight_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  wcrbf_pkg::req_payload_type   req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output wcrbf_pkg::rsp_payload_type   rsp_payload,
   input  logic                         csr_we,
   input  logic [wcrbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wcrbf_pkg::COORD_W-1:0]   csr_wdata
);
   import wcrbf_pkg::*;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned REM_W      = 35;
   localparam int unsigned ST_MAG     = 0;
   localparam int unsigned ST_SQR     = 1;
   localparam int unsigned ST_SUM     = 2;
   localparam int unsigned ST_PROD    = ST_SUM + SQRT_STEPS + 1;
   localparam int unsigned ST_TF      = ST_PROD + 1;
   localparam int unsigned ST_T2      = ST_TF + 1;
   localparam int unsigned ST_T4      = ST_T2 + 1;
   localparam int unsigned ST_OUT     = ST_T4 + 1;
   localparam int unsigned NUM_STAGES = ST_OUT + 1;

   // configuration
   logic [COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff, inv_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         center_z_ff   <= '0;
         inv_radius_ff <= INV_RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_x_ff   <= csr_wdata;
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata;
            CSR_CENTER_Z:   center_z_ff   <= csr_wdata;
            CSR_INV_RADIUS: inv_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits and stage enables
   logic [NUM_STAGES-1:0] vld_ff, vld_in, en;

   always_comb begin
      vld_in[0] = req_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
      en[ST_OUT] = !vld_ff[ST_OUT] || !rsp_stall;
      for (int i = ST_OUT - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !en[ST_MAG];

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   // stage: absolute differences
   logic [COORD_W-1:0] mag_ff [3];
   logic [COORD_W-1:0] mag_in [3];

   always_comb begin
      mag_in[0] = abs_diff(req_payload.point_x, center_x_ff);
      mag_in[1] = abs_diff(req_payload.point_y, center_y_ff);
      mag_in[2] = abs_diff(req_payload.point_z, center_z_ff);
   end

   always_ff @(posedge clock) begin
      if (en[ST_MAG]) begin
         mag_ff <= mag_in;
      end
   end

   // stage: squares
   logic [2*COORD_W-1:0] sqr_ff [3];
   logic [2*COORD_W-1:0] sqr_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sqr_in[k] = (2*COORD_W)'(mag_ff[k]) * (2*COORD_W)'(mag_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQR]) begin
         sqr_ff <= sqr_in;
      end
   end

   // stage: sum of squares, then square root stages one result bit each
   logic [2*COORD_W-1:0] sq_rad_ff  [SQRT_STEPS+1];
   logic [REM_W-1:0]     sq_rem_ff  [SQRT_STEPS+1];
   logic [COORD_W-1:0]   sq_root_ff [SQRT_STEPS+1];
   logic                 sq_big_ff  [SQRT_STEPS+1];
   logic [2*COORD_W+1:0] sum_in;
   logic [REM_W-1:0]     sq_cat_in   [SQRT_STEPS];
   logic [REM_W-1:0]     sq_trial_in [SQRT_STEPS];
   logic                 sq_take_in  [SQRT_STEPS];

   assign sum_in = {2'b00, sqr_ff[0]} + {2'b00, sqr_ff[1]} + {2'b00, sqr_ff[2]};

   always_comb begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
         sq_cat_in[j]   = {sq_rem_ff[j][REM_W-3:0], sq_rad_ff[j][2*COORD_W-1 -: 2]};
         sq_trial_in[j] = {1'b0, sq_root_ff[j], 2'b01};
         sq_take_in[j]  = sq_cat_in[j] >= sq_trial_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         sq_rad_ff[0]  <= sum_in[2*COORD_W-1:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_big_ff[0]  <= |sum_in[2*COORD_W+1:2*COORD_W];
      end
      for (int j = 1; j <= SQRT_STEPS; j++) begin
         if (en[ST_SUM+j]) begin
            sq_rad_ff[j]  <= {sq_rad_ff[j-1][2*COORD_W-3:0], 2'b00};
            sq_rem_ff[j]  <= sq_take_in[j-1] ? (sq_cat_in[j-1] - sq_trial_in[j-1])
                                             : sq_cat_in[j-1];
            sq_root_ff[j] <= {sq_root_ff[j-1][COORD_W-2:0], sq_take_in[j-1]};
            sq_big_ff[j]  <= sq_big_ff[j-1];
         end
      end
   end

   // stage: scale by reciprocal radius
   logic [2*COORD_W-1:0] prod_ff, prod_in;
   logic                 prod_big_ff;

   assign prod_in = (2*COORD_W)'(sq_root_ff[SQRT_STEPS]) * (2*COORD_W)'(inv_radius_ff);

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         prod_ff     <= prod_in;
         prod_big_ff <= sq_big_ff[SQRT_STEPS];
      end
   end

   // stage: t = 1 - r, f = 1 + 4r
   logic [WEIGHT_W-1:0] t_ff, t_in;
   logic [WEIGHT_W+1:0] f_ff, f_in;
   logic                tf_out_ff, tf_out_in;

   always_comb begin
      t_in      = ONE_Q16 - {1'b0, prod_ff[31:16]};
      f_in      = {2'b00, ONE_Q16} + {1'b0, prod_ff[31:16], 2'b00};
      tf_out_in = prod_big_ff || (prod_ff[2*COORD_W-1:32] != '0);
   end

   always_ff @(posedge clock) begin
      if (en[ST_TF]) begin
         t_ff      <= t_in;
         f_ff      <= f_in;
         tf_out_ff <= tf_out_in;
      end
   end

   // stage: t^2
   logic [2*WEIGHT_W-1:0] t2_prod;
   logic [WEIGHT_W-1:0]   t2_ff;
   logic [WEIGHT_W+1:0]   t2_f_ff;
   logic                  t2_out_ff;

   assign t2_prod = (2*WEIGHT_W)'(t_ff) * (2*WEIGHT_W)'(t_ff);

   always_ff @(posedge clock) begin
      if (en[ST_T2]) begin
         t2_ff     <= t2_prod[WEIGHT_W+15:16];
         t2_f_ff   <= f_ff;
         t2_out_ff <= tf_out_ff;
      end
   end

   // stage: t^4
   logic [2*WEIGHT_W-1:0] t4_prod;
   logic [WEIGHT_W-1:0]   t4_ff;
   logic [WEIGHT_W+1:0]   t4_f_ff;
   logic                  t4_out_ff;

   assign t4_prod = (2*WEIGHT_W)'(t2_ff) * (2*WEIGHT_W)'(t2_ff);

   always_ff @(posedge clock) begin
      if (en[ST_T4]) begin
         t4_ff     <= t4_prod[WEIGHT_W+15:16];
         t4_f_ff   <= t2_f_ff;
         t4_out_ff <= t2_out_ff;
      end
   end

   // stage: weight = t^4 * f, saturated, zero when outside, output register
   logic [2*WEIGHT_W+1:0] w_prod;
   logic [WEIGHT_W+2:0]   w_full;
   rsp_payload_type       rsp_ff, rsp_in;

   always_comb begin
      w_prod = (2*WEIGHT_W+2)'(t4_ff) * (2*WEIGHT_W+2)'(t4_f_ff);
      w_full = w_prod[2*WEIGHT_W+1:16];
      rsp_in.outside = t4_out_ff;
      if (t4_out_ff) begin
         rsp_in.weight = '0;
      end else if (w_full > (WEIGHT_W+3)'(ONE_Q16)) begin
         rsp_in.weight = ONE_Q16;
      end else begin
         rsp_in.weight = w_full[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = vld_ff[ST_OUT];
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[ST_MAG])
      else $error("accepted item did not enter first stage");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.outside |-> rsp_payload.weight == '0)
      else $error("outside item with nonzero weight");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.weight <= ONE_Q16)
      else $error("weight above one");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] && rsp_stall && vld_ff[ST_T4] |=> vld_ff[ST_T4] && vld_ff[ST_OUT])
      else $error("full stage lost under stall");
`endif

endmodule

FILE: verif/wendland_c2_rbf_weight_top_test.sv
// Self-checking bench for wendland_c2_rbf_weight_top: streams 3D points, predicts
// each Wendland C2 weight and outside flag in fixed point, compares results in order.
// Depends on wcrbf_pkg and the block's RTL.
`timescale 1ns / 1ps

module wendland_c2_rbf_weight_top_test;
   import wcrbf_pkg::*;

   localparam int unsigned QUIET_LIMIT = 5000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CENTER_X;
   logic [COORD_W-1:0]   csr_wdata = '0;

   // shadow of the block's registers
   logic [31:0] ctr_x = '0;
   logic [31:0] ctr_y = '0;
   logic [31:0] ctr_z = '0;
   logic [31:0] inv_rad = INV_RADIUS_RESET;

   req_payload_type pending_points[$];
   rsp_payload_type expected_weights[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned points_sent = 0;
   int unsigned results_checked = 0;
   int unsigned outside_seen = 0;
   int unsigned zero_inside_seen = 0;
   int unsigned quiet_cycles = 0;

   wendland_c2_rbf_weight_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] root_floor(logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         if ({32'd0, trial} * {32'd0, trial} <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [63:0] axis_square(logic [31:0] a, logic [31:0] b);
      logic [32:0] diff;
      logic [32:0] mag;
      diff = {a[31], a} - {b[31], b};
      mag = diff[32] ? -diff : diff;
      return {32'd0, mag[31:0]} * {32'd0, mag[31:0]};
   endfunction

   function automatic rsp_payload_type predict_weight(req_payload_type p);
      logic [65:0] dist_sq;
      logic [63:0] scaled;
      logic [63:0] r16, t, t2, t4, f, w;
      rsp_payload_type res;
      dist_sq = {2'b0, axis_square(p.point_x, ctr_x)} + {2'b0, axis_square(p.point_y, ctr_y)}
              + {2'b0, axis_square(p.point_z, ctr_z)};
      scaled = '0;
      if (dist_sq[65:64] == 2'b0) begin
         scaled = {32'd0, root_floor(dist_sq[63:0])} * {32'd0, inv_rad};
      end
      if (dist_sq[65:64] != 2'b0 || scaled[63:32] != 32'd0) begin
         res.weight = '0;
         res.outside = 1'b1;
      end else begin
         r16 = {48'd0, scaled[31:16]};
         t = 64'd65536 - r16;
         t2 = (t * t) >> 16;
         t4 = (t2 * t2) >> 16;
         f = 64'd65536 + 4 * r16;
         w = (t4 * f) >> 16;
         if (w > 64'd65536) begin
            w = 64'd65536;
         end
         res.weight = w[WEIGHT_W-1:0];
         res.outside = 1'b0;
      end
      return res;
   endfunction

   function automatic req_payload_type pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_payload_type p;
      p.point_x = x;
      p.point_y = y;
      p.point_z = z;
      return p;
   endfunction

   // point within a cube around the center sized to the support radius
   function automatic req_payload_type near_point();
      logic [63:0] rad, span, ox, oy, oz;
      rad = (inv_rad == 32'd0) ? 64'h8000_0000 : (64'h1_0000_0000 / {32'd0, inv_rad});
      if (rad > 64'h8000_0000) begin
         rad = 64'h8000_0000;
      end
      span = 2 * rad + 1;
      ox = ({$urandom, $urandom} % span) - rad;
      oy = ({$urandom, $urandom} % span) - rad;
      oz = ({$urandom, $urandom} % span) - rad;
      return pt(ctr_x + ox[31:0], ctr_y + oy[31:0], ctr_z + oz[31:0]);
   endfunction

   task automatic flag_mismatch(string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CENTER_X:   ctr_x = val;
         CSR_CENTER_Y:   ctr_y = val;
         CSR_CENTER_Z:   ctr_z = val;
         CSR_INV_RADIUS: inv_rad = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_control_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] inv);
      write_register(CSR_CENTER_X, x);
      write_register(CSR_CENTER_Y, y);
      write_register(CSR_CENTER_Z, z);
      write_register(CSR_INV_RADIUS, inv);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_points.size() != 0 || req_valid || expected_weights.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_weights.push_back(predict_weight(req_payload));
            points_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_points.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(0, 99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_weights.size() == 0) begin
            flag_mismatch($sformatf("unexpected item weight=%0d outside=%0b",
                                    rsp_payload.weight, rsp_payload.outside));
         end else begin
            rsp_payload_type exp_r;
            exp_r = expected_weights.pop_front();
            if (rsp_payload.weight !== exp_r.weight) begin
               flag_mismatch($sformatf("item %0d weight got %0d want %0d",
                                       results_checked, rsp_payload.weight, exp_r.weight));
            end
            if (rsp_payload.outside !== exp_r.outside) begin
               flag_mismatch($sformatf("item %0d outside got %0b want %0b",
                                       results_checked, rsp_payload.outside, exp_r.outside));
            end
            if (exp_r.outside) begin
               outside_seen++;
            end else if (exp_r.weight == '0) begin
               zero_inside_seen++;
            end
         end
         results_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("wendland_c2_rbf_weight_top_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned random_count[8];
      random_count = '{150, 250, 200, 200, 150, 300, 300, 330};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 9;
            recv_stall_pct = 62;
         end else if (phase < 6) begin
            send_idle_pct = 62;
            recv_stall_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         case (phase)
            0: begin
               // reset settings: center at origin, radius 1.0
               pending_points.push_back(pt(32'd0, 32'd0, 32'd0));
               pending_points.push_back(pt(32'd65536, 32'd0, 32'd0));
               pending_points.push_back(pt(32'd65535, 32'd0, 32'd0));
               pending_points.push_back(pt(32'd0, -32'sd65535, 32'd0));
               pending_points.push_back(pt(32'd32768, 32'd0, 32'd0));
               pending_points.push_back(pt(32'd0, 32'd0, -32'sd32768));
               pending_points.push_back(pt(32'd37837, 32'd37837, 32'd37837));
               pending_points.push_back(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
               pending_points.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
               pending_points.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
               pending_points.push_back(pt(32'd1, 32'hFFFF_FFFF, 32'd1));
            end
            1: set_control_point($urandom_range(0, 32'h000F_FFFF), -$urandom_range(0, 32'h000F_FFFF),
                                 $urandom, 32'd65536);
            2: begin
               set_control_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
               pending_points.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
               pending_points.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
               pending_points.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
               pending_points.push_back(pt(32'd0, 32'd0, 32'd0));
            end
            3: set_control_point($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
            4: set_control_point($urandom, $urandom, $urandom, 32'd0);
            5: set_control_point($urandom, $urandom, $urandom,
                                 $urandom_range(32'h0000_1000, 32'h0010_0000));
            6: set_control_point($urandom, $urandom, $urandom, 32'h0004_0000);
            default: set_control_point($urandom, $urandom, $urandom, $urandom);
         endcase
         for (int n = 0; n < random_count[phase]; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               pending_points.push_back(pt($urandom, $urandom, $urandom));
            end else begin
               pending_points.push_back(near_point());
            end
         end
         wait_drained();
      end
      repeat (60) @(posedge clock);
      if (expected_weights.size() != 0) begin
         flag_mismatch($sformatf("%0d items never returned", expected_weights.size()));
      end
      $display("Sent %0d points over 8 register settings; %0d results checked.",
               points_sent, results_checked);
      $display("Outside support: %0d; zero weight inside support: %0d; mismatches: %0d.",
               outside_seen, zero_inside_seen, error_count);
      if (error_count == 0) begin
         $display("wendland_c2_rbf_weight_top_test: PASS");
      end else begin
         $display("wendland_c2_rbf_weight_top_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/wcrbf_pkg.sv
rtl/core/wendland_c2_rbf_weight_top.sv
verif/wendland_c2_rbf_weight_top_test.sv
